[hdl/skm_pkg.sv]
// Package with the beat types, queue command types and constants of the sorted kink merge.
`timescale 1ns / 1ps

package skm_pkg;

    localparam int CNT_W       = 7;
    localparam int MAX_RESULTS = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [63:0] EMPTY_KEY = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] kink_time;
        logic [63:0] kink_key;
        logic [15:0] kink_site;
        logic        batch_last;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] entry_time;
        logic        state_before;
        logic        state_after;
        logic [63:0] entry_key;
        logic [15:0] entry_site;
        logic        entry_last;
        logic        batch_error;
    } out_beat_t;

    typedef struct packed {
        logic [31:0] kink_time;
        logic [63:0] kink_key;
        logic [15:0] kink_site;
    } batch_entry_t;

    typedef struct packed {
        logic [31:0] entry_time;
        logic [63:0] entry_key;
        logic [15:0] entry_site;
        logic        state_before;
        logic        state_after;
    } chain_entry_t;

    typedef struct packed {
        logic             slot;
        logic [CNT_W-1:0] count;
    } merge_cmd_t;

    typedef struct packed {
        logic valid;
        logic slot;
    } slot_release_t;

endpackage

[hdl/sorted_kink_merge_double_buffer_top.sv]
// Top level of the sorted kink merge with two chain banks used in turn.
`timescale 1ns / 1ps

// Each input beat carries one new kink of a batch; the beat with batch_last set ends the
// batch. Input beats are taken one per cycle into one of two batch slots, so a second
// batch can be loaded while the first is merged. The input stalls only when both slots
// still wait for the merge engine. A beat that is not last of its batch gives no output.
// On the last beat the merge engine walks the batch into the live chain, a read state
// and a step state per step, at most one step per new kink, per existing entry and one
// to finish. It then swaps banks and sends the chain, at most 32 beats, each one read
// from the chain memory and then sent, with entry_last on the final beat. A batch that
// would overflow the capacity gives a single beat with batch_error and entry_last set.
// The output is registered; when the receiver holds out_ready low the engine waits and
// the input keeps filling the free batch slot. The rate is set by the single read port
// of the chain memory, whose read data is registered before each step. Reset empties
// the chain, selects bank zero and clears the initial spin state. cfg_wr_en writes
// initial_state; the user must use it only while no batch is in progress (unenforced).
module sorted_kink_merge_double_buffer_top #(
    parameter int CHAIN_CAPACITY = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  skm_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output skm_pkg::out_beat_t out_data
);
    import skm_pkg::*;

    localparam int AW = $clog2(2 * CHAIN_CAPACITY);

    logic          initial_state_reg;
    logic          cmd_push;
    merge_cmd_t    cmd_push_data;
    logic          cmd_pop;
    logic          cmd_valid;
    merge_cmd_t    cmd_head;
    slot_release_t release_slot;
    logic          batch_rd_en;
    logic [AW-1:0] batch_rd_addr;
    batch_entry_t  batch_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_state_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            initial_state_reg <= cfg_wr_data;
        end
    end

    skm_front #(
        .CHAIN_CAPACITY(CHAIN_CAPACITY)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .cmd_push     (cmd_push),
        .cmd_data     (cmd_push_data),
        .release_slot (release_slot),
        .batch_rd_en  (batch_rd_en),
        .batch_rd_addr(batch_rd_addr),
        .batch_rd_data(batch_rd_data)
    );

    skm_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_push_data),
        .pop       (cmd_pop),
        .head_valid(cmd_valid),
        .head_data (cmd_head)
    );

    skm_back #(
        .CHAIN_CAPACITY(CHAIN_CAPACITY)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .initial_state(initial_state_reg),
        .cmd_valid    (cmd_valid),
        .cmd_data     (cmd_head),
        .cmd_pop      (cmd_pop),
        .release_slot (release_slot),
        .batch_rd_en  (batch_rd_en),
        .batch_rd_addr(batch_rd_addr),
        .batch_rd_data(batch_rd_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule

[hdl/skm_front.sv]
// Input side: buffers batch beats into two slots and queues a merge command per batch.
`timescale 1ns / 1ps

module skm_front #(
    parameter int CHAIN_CAPACITY = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  skm_pkg::in_beat_t      in_data,
    output logic                   cmd_push,
    output skm_pkg::merge_cmd_t    cmd_data,
    input  skm_pkg::slot_release_t release_slot,
    input  logic                   batch_rd_en,
    input  logic [$clog2(2*CHAIN_CAPACITY)-1:0] batch_rd_addr,
    output skm_pkg::batch_entry_t  batch_rd_data
);
    import skm_pkg::*;

    localparam int AW = $clog2(2 * CHAIN_CAPACITY);
    localparam int CW = $clog2(CHAIN_CAPACITY + 2);
    localparam logic [AW-1:0] SLOT_OFS = AW'(CHAIN_CAPACITY);
    localparam logic [CW-1:0] CAP_CW   = CW'(CHAIN_CAPACITY);
    localparam logic [CW-1:0] OVER_CW  = CW'(CHAIN_CAPACITY + 1);

    batch_entry_t batch_mem [2*CHAIN_CAPACITY];

    logic [1:0]    busy_reg, busy_next;
    logic          wslot_reg, wslot_next;
    logic [CW-1:0] wcount_reg, wcount_next;
    logic          accept;
    logic          room;
    logic [CW-1:0] count_after;
    logic [AW-1:0] wr_addr;

    assign in_ready    = !busy_reg[wslot_reg];
    assign accept      = in_valid && in_ready;
    assign room        = wcount_reg < CAP_CW;
    assign count_after = room ? wcount_reg + 1'b1 : OVER_CW;
    assign wr_addr     = (wslot_reg ? SLOT_OFS : '0) + AW'(wcount_reg);

    assign cmd_push       = accept && in_data.batch_last;
    assign cmd_data.slot  = wslot_reg;
    assign cmd_data.count = CNT_W'(count_after);

    always_comb
    begin
        busy_next   = busy_reg;
        wslot_next  = wslot_reg;
        wcount_next = wcount_reg;
        if (release_slot.valid)
        begin
            busy_next[release_slot.slot] = 1'b0;
        end
        if (accept)
        begin
            if (in_data.batch_last)
            begin
                busy_next[wslot_reg] = 1'b1;
                wslot_next           = !wslot_reg;
                wcount_next          = '0;
            end
            else
            begin
                wcount_next = count_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= '0;
            wslot_reg  <= 1'b0;
            wcount_reg <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            wslot_reg  <= wslot_next;
            wcount_reg <= wcount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && room)
        begin
            batch_mem[wr_addr] <= '{kink_time: in_data.kink_time,
                                    kink_key:  in_data.kink_key,
                                    kink_site: in_data.kink_site};
        end
        if (batch_rd_en)
        begin
            batch_rd_data <= batch_mem[batch_rd_addr];
        end
    end

endmodule

[hdl/skm_cmd_fifo.sv]
// Two-entry queue of merge commands between the input side and the merge engine.
`timescale 1ns / 1ps

module skm_cmd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  skm_pkg::merge_cmd_t push_data,
    input  logic                pop,
    output logic                head_valid,
    output skm_pkg::merge_cmd_t head_data
);
    import skm_pkg::*;

    merge_cmd_t entry_reg [QUEUE_DEPTH];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign head_valid = fill_reg != 2'd0;
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/skm_back.sv]
// Merge engine: walks the batch into the live chain bank, swaps banks and sends out the chain.
`timescale 1ns / 1ps

module skm_back #(
    parameter int CHAIN_CAPACITY = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   initial_state,
    input  logic                   cmd_valid,
    input  skm_pkg::merge_cmd_t    cmd_data,
    output logic                   cmd_pop,
    output skm_pkg::slot_release_t release_slot,
    output logic                   batch_rd_en,
    output logic [$clog2(2*CHAIN_CAPACITY)-1:0] batch_rd_addr,
    input  skm_pkg::batch_entry_t  batch_rd_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output skm_pkg::out_beat_t     out_data
);
    import skm_pkg::*;

    localparam int AW = $clog2(2 * CHAIN_CAPACITY);
    localparam int CW = $clog2(CHAIN_CAPACITY + 2);
    localparam logic [AW-1:0] BANK_OFS = AW'(CHAIN_CAPACITY);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_STEP  = 6'b000100,
        ST_ERROR = 6'b001000,
        ST_EM_RD = 6'b010000,
        ST_EM_WR = 6'b100000
    } back_state_t;

    chain_entry_t chain_mem [2*CHAIN_CAPACITY];
    chain_entry_t chain_rd_q;

    back_state_t   state_reg, state_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] e_reg, e_next;
    logic [CW-1:0] emit_reg, emit_next;
    logic [CW-1:0] chain_count_reg, chain_count_next;
    logic          live_bank_reg, live_bank_next;
    logic          slot_reg, slot_next;
    logic          st_reg, st_next;
    logic          out_valid_reg, out_valid_next;
    out_beat_t     out_data_reg, out_data_next;

    logic          chain_rd_en;
    logic [AW-1:0] chain_rd_addr;
    logic          chain_wr_en;
    logic [AW-1:0] chain_wr_addr;
    chain_entry_t  chain_wr_data;
    chain_entry_t  new_entry;
    logic [AW-1:0] src_base;
    logic [AW-1:0] dst_base;
    logic          out_free;
    logic          new_left;
    logic          old_left;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign src_base  = live_bank_reg ? BANK_OFS : '0;
    assign dst_base  = live_bank_reg ? '0 : BANK_OFS;
    assign new_left  = i_reg < n_reg;
    assign old_left  = j_reg < chain_count_reg;

    assign new_entry = '{entry_time:   batch_rd_data.kink_time,
                         entry_key:    batch_rd_data.kink_key,
                         entry_site:   batch_rd_data.kink_site,
                         state_before: st_reg,
                         state_after:  st_reg};

    always_comb
    begin
        state_next       = state_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        k_next           = k_reg;
        n_next           = n_reg;
        e_next           = e_reg;
        emit_next        = emit_reg;
        chain_count_next = chain_count_reg;
        live_bank_next   = live_bank_reg;
        slot_next        = slot_reg;
        st_next          = st_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_data_next    = out_data_reg;
        cmd_pop          = 1'b0;
        release_slot     = '0;
        batch_rd_en      = 1'b0;
        batch_rd_addr    = (slot_reg ? BANK_OFS : '0) + AW'(i_reg);
        chain_rd_en      = 1'b0;
        chain_rd_addr    = src_base + AW'(j_reg);
        chain_wr_en      = 1'b0;
        chain_wr_addr    = dst_base + AW'(k_reg);
        chain_wr_data    = chain_rd_q;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop   = 1'b1;
                    slot_next = cmd_data.slot;
                    n_next    = CW'(cmd_data.count);
                    if (32'(cmd_data.count) + 32'(chain_count_reg) > CHAIN_CAPACITY)
                    begin
                        release_slot = '{valid: 1'b1, slot: cmd_data.slot};
                        state_next   = ST_ERROR;
                    end
                    else
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        k_next     = '0;
                        st_next    = initial_state;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                batch_rd_en = 1'b1;
                chain_rd_en = 1'b1;
                state_next  = ST_STEP;
            end
            ST_STEP:
            begin
                state_next = ST_READ;
                if (new_left && old_left)
                begin
                    if (chain_rd_q.entry_key == EMPTY_KEY)
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    else if (batch_rd_data.kink_time < chain_rd_q.entry_time)
                    begin
                        chain_wr_en   = 1'b1;
                        chain_wr_data = new_entry;
                        i_next        = i_reg + 1'b1;
                        k_next        = k_reg + 1'b1;
                    end
                    else
                    begin
                        chain_wr_en = 1'b1;
                        st_next     = chain_rd_q.state_after;
                        j_next      = j_reg + 1'b1;
                        k_next      = k_reg + 1'b1;
                    end
                end
                else if (old_left)
                begin
                    chain_wr_en = 1'b1;
                    j_next      = j_reg + 1'b1;
                    k_next      = k_reg + 1'b1;
                end
                else if (new_left)
                begin
                    chain_wr_en   = 1'b1;
                    chain_wr_data = new_entry;
                    i_next        = i_reg + 1'b1;
                    k_next        = k_reg + 1'b1;
                end
                else
                begin
                    live_bank_next   = !live_bank_reg;
                    chain_count_next = k_reg;
                    if (32'(k_reg) < MAX_RESULTS)
                    begin
                        emit_next = k_reg;
                    end
                    else
                    begin
                        emit_next = CW'(MAX_RESULTS);
                    end
                    e_next       = '0;
                    release_slot = '{valid: 1'b1, slot: slot_reg};
                    state_next   = ST_EM_RD;
                end
            end
            ST_ERROR:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next             = '0;
                    out_data_next.entry_last  = 1'b1;
                    out_data_next.batch_error = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            ST_EM_RD:
            begin
                chain_rd_en   = 1'b1;
                chain_rd_addr = src_base + AW'(e_reg);
                state_next    = ST_EM_WR;
            end
            ST_EM_WR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{entry_time:   chain_rd_q.entry_time,
                                       state_before: chain_rd_q.state_before,
                                       state_after:  chain_rd_q.state_after,
                                       entry_key:    chain_rd_q.entry_key,
                                       entry_site:   chain_rd_q.entry_site,
                                       entry_last:   e_reg + 1'b1 == emit_reg,
                                       batch_error:  1'b0};
                    e_next         = e_reg + 1'b1;
                    state_next     = (e_reg + 1'b1 == emit_reg) ? ST_IDLE : ST_EM_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            chain_count_reg <= '0;
            live_bank_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            chain_count_reg <= chain_count_next;
            live_bank_reg   <= live_bank_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        n_reg        <= n_next;
        e_reg        <= e_next;
        emit_reg     <= emit_next;
        slot_reg     <= slot_next;
        st_reg       <= st_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (chain_wr_en)
        begin
            chain_mem[chain_wr_addr] <= chain_wr_data;
        end
        if (chain_rd_en)
        begin
            chain_rd_q <= chain_mem[chain_rd_addr];
        end
    end

endmodule

[hdl/skm_checker.sv]
// Port-level checker for the sorted kink merge, bound to the top level.
`timescale 1ns / 1ps

module skm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input skm_pkg::in_beat_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input skm_pkg::out_beat_t out_data
);
    import skm_pkg::*;

    // A waiting input beat keeps its contents until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input beat changed while stalled");

    // A stalled result beat keeps its contents until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // An error beat closes its merge.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.batch_error |-> out_data.entry_last)
        else $error("error beat without entry_last");

    // An error beat carries no chain entry.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.batch_error |->
            out_data.entry_key == 64'd0 && out_data.entry_time == 32'd0 &&
            out_data.entry_site == 16'd0 && !out_data.state_before &&
            !out_data.state_after)
        else $error("error beat with nonzero fields");

    // No result beat is shown at the edge where the release of reset is first seen.
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("output beat right after reset");

endmodule

bind sorted_kink_merge_double_buffer_top skm_checker u_skm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
);
